// ----- hdl/crs_pkg.sv -----
// Shared widths, constants and types for the Catmull-Rom stroke sampler.
// No dependencies; every other file refers to it by scoped names.
package crs_pkg;

  localparam int COORD_BITS  = 20;
  localparam int T_FRAC_BITS = 16;
  localparam int MAX_SAMPLES = 32;

  localparam int STEP_W  = 16;
  localparam int ACC_W   = COORD_BITS + 8;           // Horner accumulator
  localparam int MB_W    = COORD_BITS + 2;           // second multiplier operand
  localparam int PROD_W  = ACC_W + MB_W;
  localparam int TW      = T_FRAC_BITS + 1;          // t and step, up to 1.0
  localparam int SQ_W    = 2 * (COORD_BITS + 1);     // sum of two squares
  localparam int ROOT_W  = SQ_W / 2;
  localparam int DIST_W  = ROOT_W + 1;
  localparam int DVD_W   = STEP_W + T_FRAC_BITS;
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);

  localparam logic [STEP_W-1:0] STEP_DEFAULT = STEP_W'(80);
  localparam logic [TW-1:0]     T_ONE        = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0]     T_HALF       = TW'(1) << (T_FRAC_BITS - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

// ----- hdl/crs_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on crs_pkg.
module crs_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [crs_pkg::ACC_W-1:0]  a_i,
  input  logic signed [crs_pkg::MB_W-1:0]   b_i,
  output logic signed [crs_pkg::PROD_W-1:0] prod_o
);

  logic signed [crs_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= crs_pkg::PROD_W'(a_i) * crs_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/crs_sqrt.sv -----
// Floor integer square root, two radicand bits per cycle.
// Depends on crs_pkg.
module crs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [crs_pkg::SQ_W-1:0]    val_i,
  output logic                        done_o,
  output logic [crs_pkg::ROOT_W-1:0]  root_o
);

  localparam int RW = crs_pkg::ROOT_W + 3;
  localparam int CW = $clog2(crs_pkg::ROOT_W + 1);

  logic [crs_pkg::SQ_W-1:0]   val_q;
  logic [RW-1:0]              rem_q;
  logic [crs_pkg::ROOT_W-1:0] root_q;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;
  logic [RW-1:0]              rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q[RW-3:0], val_q[crs_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        val_q  <= val_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CW'(crs_pkg::ROOT_W);
      end else if (busy_q) begin
        val_q <= val_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[crs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[crs_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

`ifndef NO_ASSERTIONS
  a_sqrt_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("sqrt restarted while busy");
`endif

endmodule

// ----- hdl/crs_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on crs_pkg.
module crs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [crs_pkg::DVD_W-1:0]   dvd_i,
  input  logic [crs_pkg::DIST_W-1:0]  dsr_i,
  output logic                        done_o,
  output logic [crs_pkg::DVD_W-1:0]   quot_o
);

  localparam int RW = crs_pkg::DIST_W + 1;
  localparam int CW = $clog2(crs_pkg::DVD_W + 1);

  logic [crs_pkg::DVD_W-1:0]  dvd_q;
  logic [crs_pkg::DIST_W-1:0] dsr_q;
  logic [RW-1:0]              rem_q, rem_sh;
  logic [CW-1:0]              cnt_q;
  logic                       busy_q, done_q;

  assign rem_sh = {rem_q[RW-2:0], dvd_q[crs_pkg::DVD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        dvd_q  <= dvd_i;
        dsr_q  <= dsr_i;
        rem_q  <= '0;
        cnt_q  <= CW'(crs_pkg::DVD_W);
      end else if (busy_q) begin
        // quotient bits shift in where the dividend bits leave
        if (rem_sh >= {1'b0, dsr_q}) begin
          rem_q <= rem_sh - {1'b0, dsr_q};
          dvd_q <= {dvd_q[crs_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          dvd_q <= {dvd_q[crs_pkg::DVD_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

`ifndef NO_ASSERTIONS
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule

// ----- hdl/catmull_rom_stroke_sampler_top.sv -----
// Catmull-Rom stroke sampler: sequencer, control-point window, output stage.
// Depends on crs_pkg, crs_mul, crs_sqrt, crs_div.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o    | vertex_x_i, vertex_y_i, stroke_end_i
//  out      | out_valid_o / out_ready_i  | point_x_o, point_y_o, run_last_o, stroke_last_o
//  cfg      | cfg_we_i                   | cfg_wdata_i (step_length)
//
// Segment and sample work all runs through the single shared multiplier (Horner
// steps and squares), two square roots per segment and at most one divide; an end
// vertex runs up to two segments.
// in_ready_o is high only between vertices. The sequencer stalls while the output
// register is full; one sample is held back so the last one can be flagged.
// Reset clears the window, vertex count and step_length to 80.
module catmull_rom_stroke_sampler_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [crs_pkg::COORD_BITS-1:0] vertex_x_i,
  input  logic signed [crs_pkg::COORD_BITS-1:0] vertex_y_i,
  input  logic                                  stroke_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [crs_pkg::COORD_BITS-1:0] point_x_o,
  output logic signed [crs_pkg::COORD_BITS-1:0] point_y_o,
  output logic                                  run_last_o,
  output logic                                  stroke_last_o,
  input  logic                                  cfg_we_i,
  input  logic [crs_pkg::STEP_W-1:0]            cfg_wdata_i
);

  localparam int C  = crs_pkg::COORD_BITS;
  localparam int AW = crs_pkg::ACC_W;
  localparam int F  = crs_pkg::T_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SHIFT, S_SEG, S_EV_INIT, S_EV_MUL, S_EV_ADD,
    S_SQ_MUL, S_SQ_ACC, S_SQRT, S_DIVST, S_DIV, S_SAMP, S_PUSH, S_FLUSH
  } state_e;

  state_e state_q;

  logic [crs_pkg::STEP_W-1:0] step_len_q;
  crs_pkg::coord_t wx_q [3];
  crs_pkg::coord_t wy_q [3];
  crs_pkg::coord_t in_x_q, in_y_q, ex_q, ey_q, pend_x_q, pend_y_q;
  crs_pkg::coord_t out_x_q, out_y_q;
  logic        in_end_q, pend_v_q, out_v_q, out_rl_q, out_sl_q;
  logic [1:0]  seen_q, kseen_q, hstep_q;
  logic        phase_q, cs_q, ret_mid_q, tgt_q, sq_idx_q;
  logic signed [AW-1:0] acc_q;
  logic [crs_pkg::TW-1:0]     t_q, step_q;
  logic [crs_pkg::CNT_W-1:0]  cnt_q;
  logic [crs_pkg::SQ_W-1:0]   sum_q, sum_d;
  logic [crs_pkg::DIST_W-1:0] dist_q;

  // control points for the selected coordinate
  logic signed [AW-1:0] q0, q1, q2, q3, cf_c, cf_b, cf_a, cf_d, coef_sel;
  logic signed [AW-1:0] ev_sum, ev_half;
  crs_pkg::coord_t      ev_res;
  logic signed [C:0]    diff;
  crs_pkg::coord_t      mid_c, tgt_c;

  logic signed [AW-1:0]             mul_a;
  logic signed [crs_pkg::MB_W-1:0]  mul_b;
  logic signed [crs_pkg::PROD_W-1:0] prod;
  logic                             mul_en;

  logic sqrt_start, sqrt_done, div_start, div_done, slot;
  logic [crs_pkg::ROOT_W-1:0] root;
  logic [crs_pkg::DVD_W-1:0]  quot;
  logic [crs_pkg::STEP_W-1:0] len;

  always_comb begin
    q0 = AW'(cs_q ? wy_q[0] : wx_q[0]);
    q1 = AW'(cs_q ? wy_q[1] : wx_q[1]);
    q2 = AW'(cs_q ? wy_q[2] : wx_q[2]);
    q3 = AW'(cs_q ? in_y_q : in_x_q);
    cf_c = -q0 + 3 * q1 - 3 * q2 + q3;
    cf_b = 2 * q0 - 5 * q1 + 4 * q2 - q3;
    cf_a = q2 - q0;
    cf_d = 2 * q1;
    case (hstep_q)
      2'd0:    coef_sel = cf_b;
      2'd1:    coef_sel = cf_a;
      default: coef_sel = cf_d;
    endcase
    ev_sum  = coef_sel + prod[AW+F-1:F];
    ev_half = (ev_sum + AW'(1)) >>> 1;
    if (ev_half > crs_pkg::SAT_HI)      ev_res = crs_pkg::SAT_HI[C-1:0];
    else if (ev_half < crs_pkg::SAT_LO) ev_res = crs_pkg::SAT_LO[C-1:0];
    else                                ev_res = ev_half[C-1:0];

    mid_c = sq_idx_q ? ey_q : ex_q;
    if (tgt_q) tgt_c = sq_idx_q ? wy_q[2] : wx_q[2];
    else       tgt_c = sq_idx_q ? wy_q[1] : wx_q[1];
    diff = (C+1)'(mid_c) - (C+1)'(tgt_c);

    mul_en = (state_q == S_EV_MUL) || (state_q == S_SQ_MUL);
    if (state_q == S_SQ_MUL) begin
      mul_a = AW'(diff);
      mul_b = crs_pkg::MB_W'(diff);
    end else begin
      mul_a = acc_q;
      mul_b = {{(crs_pkg::MB_W - crs_pkg::TW){1'b0}}, t_q};
    end

    sum_d      = sum_q + prod[crs_pkg::SQ_W-1:0];
    sqrt_start = (state_q == S_SQ_ACC) && sq_idx_q;
    div_start  = (state_q == S_DIVST) && (dist_q != '0);
    len        = (step_len_q == '0) ? crs_pkg::STEP_DEFAULT : step_len_q;
    slot       = !out_v_q || out_ready_i;
  end

  crs_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  crs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sum_d),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  crs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   ({len, {F{1'b0}}}),
    .dsr_i   (dist_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_len_q <= crs_pkg::STEP_DEFAULT;
      seen_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        wx_q[i] <= '0;
        wy_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) step_len_q <= cfg_wdata_i;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_x_q   <= vertex_x_i;
            in_y_q   <= vertex_y_i;
            in_end_q <= stroke_end_i;
            kseen_q  <= seen_q;
            state_q  <= S_START;
          end
        end
        S_START: begin
          if (kseen_q == 2'd0) begin
            if (!in_end_q) begin
              for (int i = 0; i < 3; i++) begin
                wx_q[i] <= in_x_q;
                wy_q[i] <= in_y_q;
              end
              seen_q <= 2'd1;
            end
            state_q <= S_IDLE;
          end else if (kseen_q >= 2'd2) begin
            phase_q <= 1'b0;
            state_q <= S_SEG;
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          wx_q[0] <= wx_q[1];
          wy_q[0] <= wy_q[1];
          wx_q[1] <= wx_q[2];
          wy_q[1] <= wy_q[2];
          wx_q[2] <= in_x_q;
          wy_q[2] <= in_y_q;
          if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
          if (in_end_q) begin
            phase_q <= 1'b1;
            state_q <= S_SEG;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_SEG: begin
          cnt_q     <= '0;
          t_q       <= crs_pkg::T_HALF;
          ret_mid_q <= 1'b1;
          cs_q      <= 1'b0;
          state_q   <= S_EV_INIT;
        end
        S_EV_INIT: begin
          acc_q   <= cf_c;
          hstep_q <= 2'd0;
          state_q <= S_EV_MUL;
        end
        S_EV_MUL: state_q <= S_EV_ADD;
        S_EV_ADD: begin
          acc_q   <= ev_sum;
          hstep_q <= hstep_q + 2'd1;
          state_q <= S_EV_MUL;
          if (hstep_q == 2'd2) begin
            if (!cs_q) begin
              ex_q    <= ev_res;
              cs_q    <= 1'b1;
              state_q <= S_EV_INIT;
            end else begin
              ey_q <= ev_res;
              if (ret_mid_q) begin
                tgt_q    <= 1'b0;
                sq_idx_q <= 1'b0;
                sum_q    <= '0;
                state_q  <= S_SQ_MUL;
              end else begin
                state_q <= S_PUSH;
              end
            end
          end
        end
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          sum_q <= sum_d;
          if (!sq_idx_q) begin
            sq_idx_q <= 1'b1;
            state_q  <= S_SQ_MUL;
          end else begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (!tgt_q) begin
              dist_q   <= crs_pkg::DIST_W'(root);
              tgt_q    <= 1'b1;
              sq_idx_q <= 1'b0;
              sum_q    <= '0;
              state_q  <= S_SQ_MUL;
            end else begin
              dist_q  <= dist_q + crs_pkg::DIST_W'(root);
              state_q <= S_DIVST;
            end
          end
        end
        S_DIVST: begin
          t_q       <= '0;
          cnt_q     <= '0;
          ret_mid_q <= 1'b0;
          if (dist_q == '0) begin
            step_q  <= crs_pkg::T_ONE;
            state_q <= S_SAMP;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (quot[crs_pkg::DVD_W-1:F] != '0) step_q <= crs_pkg::T_ONE;
            else if (quot == '0)                step_q <= crs_pkg::TW'(1);
            else                                step_q <= crs_pkg::TW'(quot[F-1:0]);
            state_q <= S_SAMP;
          end
        end
        S_SAMP: begin
          if ((cnt_q < crs_pkg::CNT_W'(crs_pkg::MAX_SAMPLES)) && (t_q < crs_pkg::T_ONE)) begin
            cs_q    <= 1'b0;
            state_q <= S_EV_INIT;
          end else begin
            state_q <= phase_q ? S_FLUSH : S_SHIFT;
          end
        end
        S_PUSH: begin
          if (!pend_v_q || slot) begin
            if (pend_v_q) begin
              out_x_q  <= pend_x_q;
              out_y_q  <= pend_y_q;
              out_rl_q <= 1'b0;
              out_sl_q <= 1'b0;
              out_v_q  <= 1'b1;
            end
            pend_x_q <= ex_q;
            pend_y_q <= ey_q;
            pend_v_q <= 1'b1;
            t_q      <= t_q + step_q;
            cnt_q    <= cnt_q + crs_pkg::CNT_W'(1);
            state_q  <= S_SAMP;
          end
        end
        S_FLUSH: begin
          if (!pend_v_q || slot) begin
            if (pend_v_q) begin
              // end of stroke: last point snaps to the final vertex, unless a two-vertex stroke gave one sample
              if (in_end_q && ((kseen_q >= 2'd2) || (cnt_q > crs_pkg::CNT_W'(1)))) begin
                out_x_q <= in_x_q;
                out_y_q <= in_y_q;
              end else begin
                out_x_q <= pend_x_q;
                out_y_q <= pend_y_q;
              end
              out_rl_q <= 1'b1;
              out_sl_q <= in_end_q;
              out_v_q  <= 1'b1;
              pend_v_q <= 1'b0;
            end
            if (in_end_q) begin
              seen_q <= '0;
              for (int i = 0; i < 3; i++) begin
                wx_q[i] <= '0;
                wy_q[i] <= '0;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_v_q;
  assign point_x_o     = out_x_q;
  assign point_y_o     = out_y_q;
  assign run_last_o    = out_rl_q;
  assign stroke_last_o = out_sl_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready right after accept");
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SAMP) |-> (step_q != '0)) else $error("zero sample step");
  a_pend_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q) else $error("held sample left at idle");
`endif

endmodule

// ----- tb/tb_catmull_rom_stroke_sampler_top.sv -----
// Self-checking bench for the Catmull-Rom stroke sampler top level.
// Depends on crs_pkg and catmull_rom_stroke_sampler_top; the curve math is predicted inline.
module tb_catmull_rom_stroke_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CMAX = (64'sd1 <<< (crs_pkg::COORD_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [crs_pkg::COORD_BITS-1:0] px;
    logic [crs_pkg::COORD_BITS-1:0] py;
    bit                             rl;
    bit                             sl;
  } sample_t;

  typedef struct {
    longint x;
    longint y;
    bit     e;
    bit     chk;  // fixed result typed in
    longint ex;
    longint ey;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, stroke_end = 0, cfg_we = 0;
  logic in_ready, out_valid, run_last, stroke_last;
  logic signed [crs_pkg::COORD_BITS-1:0] vx = '0, vy = '0, ox, oy;
  logic [crs_pkg::STEP_W-1:0] cfg_wdata = '0;

  sample_t samples_due[$];
  row_t    rows[$];
  longint  win_x[3], win_y[3];
  int      seen_cnt;
  longint  spacing;
  int      errors = 0;
  int      cycles = 0;
  int      hold_off = 0;
  bit      long_hold = 0;

  always #6 clk = ~clk;

  catmull_rom_stroke_sampler_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .vertex_x_i(vx), .vertex_y_i(vy), .stroke_end_i(stroke_end),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .point_x_o(ox), .point_y_o(oy), .run_last_o(run_last), .stroke_last_o(stroke_last),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  function automatic longint fshift(longint v, int s);
    return v >>> s;  // arithmetic shift floors
  endfunction

  function automatic longint clip(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic longint curve_at(longint p0, longint p1, longint p2, longint p3,
                                      longint t);
    longint c, b, a, acc;
    c = -p0 + 3 * p1 - 3 * p2 + p3;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    a = p2 - p0;
    acc = b + fshift(c * t, crs_pkg::T_FRAC_BITS);
    acc = a + fshift(acc * t, crs_pkg::T_FRAC_BITS);
    acc = 2 * p1 + fshift(acc * t, crs_pkg::T_FRAC_BITS);
    return clip(fshift(acc + 1, 1));
  endfunction

  // Coordinates fit in 20 bits, so squares never saturate.
  function automatic longint root_floor(longint v);
    longint r;
    r = longint'($floor($sqrt(real'(v))));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic longint chord(longint ax, longint ay, longint bx, longint by);
    return root_floor((ax - bx) * (ax - bx) + (ay - by) * (ay - by));
  endfunction

  function automatic int sample_segment(longint nx, longint ny);
    longint mx, my, seg_len, stp, t;
    int k;
    mx = curve_at(win_x[0], win_x[1], win_x[2], nx, 1 << (crs_pkg::T_FRAC_BITS - 1));
    my = curve_at(win_y[0], win_y[1], win_y[2], ny, 1 << (crs_pkg::T_FRAC_BITS - 1));
    seg_len = chord(mx, my, win_x[1], win_y[1]) + chord(mx, my, win_x[2], win_y[2]);
    stp = 1 << crs_pkg::T_FRAC_BITS;
    if (seg_len != 0) begin
      stp = ((spacing == 0 ? 80 : spacing) << crs_pkg::T_FRAC_BITS) / seg_len;
      if (stp == 0) stp = 1;
    end
    t = 0;
    for (k = 0; k < crs_pkg::MAX_SAMPLES && t < (1 << crs_pkg::T_FRAC_BITS); k++) begin
      samples_due.push_back('{
        crs_pkg::COORD_BITS'(curve_at(win_x[0], win_x[1], win_x[2], nx, t)),
        crs_pkg::COORD_BITS'(curve_at(win_y[0], win_y[1], win_y[2], ny, t)), 0, 0});
      t += stp;
    end
    return k;
  endfunction

  // Returns the number of samples this vertex queues.
  function automatic int predict_vertex(longint x, longint y, bit e);
    int cnt, k, n;
    k = seen_cnt;
    cnt = 0;
    if (k == 0) begin
      for (int i = 0; i < 3; i++) begin win_x[i] = x; win_y[i] = y; end
      seen_cnt = 1;
    end else begin
      if (k >= 2) cnt += sample_segment(x, y);
      win_x[0] = win_x[1]; win_y[0] = win_y[1];
      win_x[1] = win_x[2]; win_y[1] = win_y[2];
      win_x[2] = x;        win_y[2] = y;
      if (k < 3) seen_cnt = k + 1;
    end
    if (e) begin
      if (k >= 1) begin
        n = sample_segment(x, y);
        cnt += n;
        if (k >= 2 || n > 1) begin
          samples_due[$].px = x[crs_pkg::COORD_BITS-1:0];
          samples_due[$].py = y[crs_pkg::COORD_BITS-1:0];
        end
        samples_due[$].sl = 1;
      end
      for (int i = 0; i < 3; i++) begin win_x[i] = 0; win_y[i] = 0; end
      seen_cnt = 0;
    end
    if (cnt > 0) samples_due[$].rl = 1;
    return cnt;
  endfunction

  task automatic send_vertex(row_t r);
    int n;
    in_valid   <= 1;
    vx         <= r.x[crs_pkg::COORD_BITS-1:0];
    vy         <= r.y[crs_pkg::COORD_BITS-1:0];
    stroke_end <= r.e;
    do @(posedge clk); while (!in_ready);
    n = predict_vertex(r.x, r.y, r.e);
    if (r.chk && (n != 1 || samples_due[$].px !== r.ex[crs_pkg::COORD_BITS-1:0]
                  || samples_due[$].py !== r.ey[crs_pkg::COORD_BITS-1:0])) begin
      $display("%0t prediction disagrees with table: exp (%0d,%0d)", $time, r.ex, r.ey);
      errors++;
    end
    // burst-and-gap pacing
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_spacing(logic [crs_pkg::STEP_W-1:0] v);
    in_valid <= 0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);  // an item may still be running with nothing to emit
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    spacing = v;
  endtask

  function automatic longint rand_coord(int mode);
    case (mode)
      0: return longint'($urandom_range(0, 1 << crs_pkg::COORD_BITS)
                         & ((1 << crs_pkg::COORD_BITS) - 1))
                - (1 << (crs_pkg::COORD_BITS - 1));
      default: return longint'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  task automatic random_strokes(int nvert);
    int len, mode;
    longint x, y;
    while (nvert > 0) begin
      len  = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 8);
      mode = $urandom_range(0, 7) == 0 ? 0 : 1;
      x = rand_coord(mode);
      y = rand_coord(mode);
      for (int i = 0; i < len; i++) begin
        send_vertex('{x, y, i == len - 1, 0, 0, 0});
        if (mode == 0) begin
          x = rand_coord(0); y = rand_coord(0);
        end else begin
          x = clip(x + longint'($urandom_range(0, 600)) - 300);
          y = clip(y + longint'($urandom_range(0, 600)) - 300);
        end
        nvert--;
      end
    end
  endtask

  // receiver stall pattern, with one long hold so the block backs up
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 0;
    end else if (!long_hold && samples_due.size() > 40) begin
      long_hold <= 1;
      hold_off  <= 3000;
      out_ready <= 0;
    end else begin
      out_ready <= (cycles % 256 < 90) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    sample_t s;
    if (rst_n && out_valid && out_ready) begin
      if (samples_due.size() == 0) begin
        $display("%0t unexpected sample (%0d,%0d)", $time, ox, oy);
        errors++;
      end else begin
        s = samples_due.pop_front();
        if (ox !== s.px || oy !== s.py || run_last !== s.rl || stroke_last !== s.sl) begin
          $display("%0t mismatch: exp (%0d,%0d,%0b,%0b) act (%0d,%0d,%0b,%0b)", $time,
                   $signed(s.px), $signed(s.py), s.rl, s.sl, ox, oy, run_last, stroke_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL catmull_rom_stroke_sampler_top");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin win_x[i] = 0; win_y[i] = 0; end
    seen_cnt = 0;
    spacing  = 80;
    // two-vertex strokes at a point give one sample: the end vertex itself
    rows.push_back('{5, -7, 0, 0, 0, 0});
    rows.push_back('{5, -7, 1, 1, 5, -7});
    rows.push_back('{CMAX, CMIN, 0, 0, 0, 0});
    rows.push_back('{CMAX, CMIN, 1, 1, CMAX, CMIN});
    rows.push_back('{CMIN, CMAX, 1, 0, 0, 0});  // single vertex, nothing out
    rows.push_back('{CMIN, CMIN, 0, 0, 0, 0});
    rows.push_back('{CMAX, CMAX, 0, 0, 0, 0});
    rows.push_back('{CMIN, CMAX, 0, 0, 0, 0});
    rows.push_back('{CMAX, CMIN, 1, 0, 0, 0});
    rows.push_back('{0, 0, 0, 0, 0, 0});
    rows.push_back('{100, 50, 0, 0, 0, 0});
    rows.push_back('{200, 0, 0, 0, 0, 0});
    rows.push_back('{300, 300, 0, 0, 0, 0});
    rows.push_back('{-1, -1, 0, 0, 0, 0});
    rows.push_back('{40, 40, 1, 0, 0, 0});
    rows.push_back('{0, 0, 0, 0, 0, 0});
    rows.push_back('{4, 4, 1, 0, 0, 0});  // tiny segment
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i]) send_vertex(rows[i]);
    write_spacing(16'd0);
    random_strokes(90);
    write_spacing(16'd1);
    random_strokes(60);
    write_spacing(16'hFFFF);
    random_strokes(80);
    write_spacing(16'd37);
    random_strokes(240);
    in_valid <= 0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("PASS catmull_rom_stroke_sampler_top");
    end else begin
      $display("FAIL catmull_rom_stroke_sampler_top");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/crs_pkg.sv
hdl/crs_mul.sv
hdl/crs_sqrt.sv
hdl/crs_div.sv
hdl/catmull_rom_stroke_sampler_top.sv
tb/tb_catmull_rom_stroke_sampler_top.sv
